@@ rtl/pdlf_pkg.sv @@
// ----------------------------------------------------------------------------
// pdlf_pkg
// Shared types and constants of the PD line-follow steering block.
// ----------------------------------------------------------------------------
package pdlf_pkg;

  // Width of one line-sensor sample.
  localparam int unsigned SampleBits = 10;

  // Error, derivative and weighted-sum widths follow from the sample width.
  localparam int unsigned ErrW  = SampleBits + 1;
  localparam int unsigned DerW  = SampleBits + 2;
  localparam int unsigned AccW  = SampleBits + 12;
  localparam int unsigned CntW  = $clog2(AccW + 1);
  localparam int unsigned BandW = 10;
  localparam int unsigned CmpW  = (ErrW > BandW) ? ErrW : BandW;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] RegBaseSpeed  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPropGain   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDerivGain  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegGainDiv    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDeadBand   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCorrLimit  = 3'd5;

  // Register reset values.
  localparam logic [6:0] BaseSpeedRst = 7'd50;
  localparam logic [7:0] PropGainRst  = 8'd22;
  localparam logic [7:0] DerivGainRst = 8'd10;
  localparam logic [7:0] GainDivRst   = 8'd80;
  localparam logic [9:0] DeadBandRst  = 10'd20;
  localparam logic [6:0] CorrLimitRst = 7'd25;

  // Wheel speed ceiling in percent.
  localparam logic [9:0] SpeedMax = 10'd100;

  // Input word: one right and one left sample.
  typedef struct packed {
    logic [SampleBits-1:0] right_sample;
    logic [SampleBits-1:0] left_sample;
  } in_word_t;

  // Output word: wheel speeds and the saturated correction.
  typedef struct packed {
    logic [6:0]        left_speed;
    logic [6:0]        right_speed;
    logic signed [7:0] steer_correction;
  } out_word_t;

endpackage

@@ rtl/pd_line_follow_steering.sv @@
// ----------------------------------------------------------------------------
// pd_line_follow_steering
// PD steering for a differential drive: dead-zoned error, derivative, one
// shared multiplier and a bit-serial restoring divider under a sequencer.
// ----------------------------------------------------------------------------
// Flow: an accepted input word passes S_PREP, S_MULP, S_MULD, S_ABS, S_DIV
//   and S_SAT to S_OUT, which loads out_valid_o; the divider gives one bit per cycle.
// A new word is taken only in S_IDLE, once S_OUT has loaded the output register.
// Reset: registers return to their defaults, the stored error clears to zero
//   and both channels come up empty.
module pd_line_follow_steering
  import pdlf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_word_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_word_t           out_data_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MULP,
    S_MULD,
    S_ABS,
    S_DIV,
    S_SAT,
    S_OUT
  } state_e;

  state_e                 state_q;
  logic [6:0]             base_q;
  logic [7:0]             kp_q;
  logic [7:0]             kd_q;
  logic [7:0]             div_q;
  logic [9:0]             band_q;
  logic [6:0]             limit_q;
  logic signed [ErrW-1:0] last_err_q;
  in_word_t               smp_q;
  logic signed [ErrW-1:0] err_q;
  logic signed [DerW-1:0] der_q;
  logic signed [AccW-1:0] acc_q;
  logic                   neg_q;
  logic [AccW-1:0]        dvd_q;
  logic [7:0]             rem_q;
  logic [CntW-1:0]        cnt_q;
  logic signed [7:0]      corr_q;
  logic                   out_valid_q;
  out_word_t              out_q;

  // Error with dead zone: zero when its magnitude lies below the band.
  logic signed [ErrW-1:0] err_raw;
  logic [ErrW-1:0]        err_mag;
  logic signed [ErrW-1:0] err_d;
  logic signed [DerW-1:0] der_d;

  always_comb begin
    err_raw = signed'({1'b0, smp_q.right_sample}) - signed'({1'b0, smp_q.left_sample});
    err_mag = err_raw[ErrW-1] ? ErrW'(-err_raw) : ErrW'(err_raw);
    err_d   = (CmpW'(err_mag) < CmpW'(band_q)) ? '0 : err_raw;
    der_d   = DerW'(err_d) - DerW'(last_err_q);
  end

  // Shared multiplier: gain times error, then gain times derivative.
  logic signed [AccW-1:0] mul_a;
  logic signed [AccW-1:0] mul_b;
  logic signed [AccW-1:0] prod;

  always_comb begin
    if (state_q == S_MULP) begin
      mul_a = signed'({{(AccW-8){1'b0}}, kp_q});
      mul_b = signed'({{(AccW-ErrW){err_q[ErrW-1]}}, err_q});
    end else begin
      mul_a = signed'({{(AccW-8){1'b0}}, kd_q});
      mul_b = signed'({{(AccW-DerW){der_q[DerW-1]}}, der_q});
    end
    prod = mul_a * mul_b;
  end

  // One restoring divide step; a zero divisor acts as one.
  logic [7:0] div_eff;
  logic [9:0] trial;

  always_comb begin
    div_eff = (div_q == '0) ? 8'd1 : div_q;
    trial   = {1'b0, rem_q, dvd_q[AccW-1]} - {2'b0, div_eff};
  end

  // Saturation of the quotient magnitude and sign restore.
  logic [6:0]        sat_mag;
  logic signed [7:0] corr_d;

  always_comb begin
    sat_mag = (dvd_q > AccW'(limit_q)) ? limit_q : dvd_q[6:0];
    corr_d  = neg_q ? -signed'({1'b0, sat_mag}) : signed'({1'b0, sat_mag});
  end

  // Wheel speeds, each clamped to the percent range.
  logic signed [9:0] lspd_raw;
  logic signed [9:0] rspd_raw;
  logic [6:0]        lspd;
  logic [6:0]        rspd;

  always_comb begin
    lspd_raw = signed'({3'b0, base_q}) - 10'(corr_q);
    rspd_raw = signed'({3'b0, base_q}) + 10'(corr_q);
    if (lspd_raw[9]) begin
      lspd = '0;
    end else if (lspd_raw > signed'(SpeedMax)) begin
      lspd = SpeedMax[6:0];
    end else begin
      lspd = lspd_raw[6:0];
    end
    if (rspd_raw[9]) begin
      rspd = '0;
    end else if (rspd_raw > signed'(SpeedMax)) begin
      rspd = SpeedMax[6:0];
    end else begin
      rspd = rspd_raw[6:0];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= BaseSpeedRst;
      kp_q    <= PropGainRst;
      kd_q    <= DerivGainRst;
      div_q   <= GainDivRst;
      band_q  <= DeadBandRst;
      limit_q <= CorrLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegBaseSpeed: base_q  <= cfg_data_i[6:0];
        RegPropGain:  kp_q    <= cfg_data_i[7:0];
        RegDerivGain: kd_q    <= cfg_data_i[7:0];
        RegGainDiv:   div_q   <= cfg_data_i[7:0];
        RegDeadBand:  band_q  <= cfg_data_i[9:0];
        RegCorrLimit: limit_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Sequencer with the datapath registers and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_err_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // A taken word empties the output register unless the next one is loaded.
      if (out_valid_q && !out_stall_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            smp_q   <= in_data_i;
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          err_q      <= err_d;
          der_q      <= der_d;
          last_err_q <= err_d;
          state_q    <= S_MULP;
        end
        S_MULP: begin
          acc_q   <= prod;
          state_q <= S_MULD;
        end
        S_MULD: begin
          acc_q   <= acc_q + prod;
          state_q <= S_ABS;
        end
        S_ABS: begin
          neg_q   <= acc_q[AccW-1];
          dvd_q   <= acc_q[AccW-1] ? AccW'(-acc_q) : AccW'(acc_q);
          rem_q   <= '0;
          cnt_q   <= CntW'(AccW);
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (!trial[9]) begin
            rem_q <= trial[7:0];
            dvd_q <= {dvd_q[AccW-2:0], 1'b1};
          end else begin
            rem_q <= {rem_q[6:0], dvd_q[AccW-1]};
            dvd_q <= {dvd_q[AccW-2:0], 1'b0};
          end
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CntW'(1)) begin
            state_q <= S_SAT;
          end
        end
        S_SAT: begin
          corr_q  <= corr_d;
          state_q <= S_OUT;
        end
        S_OUT: begin
          // Load only once the previous word has left the output register.
          if (!out_valid_q || !out_stall_i) begin
            out_q.left_speed       <= lspd;
            out_q.right_speed      <= rspd;
            out_q.steer_correction <= corr_q;
            out_valid_q            <= 1'b1;
            state_q                <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
